>>> hdl/gyrsl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the gated yaw-rate slew limiter.
package gyrsl_pkg;

  localparam int TimeW   = 63;
  localparam int ConfW   = 10;
  localparam int ErrW    = 16;
  localparam int AgeW    = 40;
  localparam int GainW   = 21;
  localparam int LimW    = 31;
  localparam int RateW   = 32;
  localparam int ProdW   = ErrW + GainW;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 40;
  localparam int InDatW  = 160;
  localparam int OutDatW = 112;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_CONF = 3'd0,
    REG_MAX_AGE  = 3'd1,
    REG_GAIN     = 3'd2,
    REG_MAX_RATE = 3'd3,
    REG_MAX_SLEW = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [ConfW-1:0]        min_conf;
    logic [AgeW-1:0]         max_age;
    logic signed [GainW-1:0] gain;
    logic [LimW-1:0]         max_rate;
    logic [LimW-1:0]         max_slew;
  } cfg_t;

  // One classified match waiting for the rate stage.
  typedef struct packed {
    logic [TimeW-1:0]        now;
    logic signed [RateW-1:0] target;
    logic [ConfW-1:0]        conf;
    logic                    ok;
  } cmd_t;

endpackage

>>> hdl/gyrsl_front.sv
`timescale 1ns / 1ps
// Front end: gate checks, gain multiply and rate clamp.
module gyrsl_front (
  input  logic                       clk,
  input  logic                       rst,
  input  gyrsl_pkg::cfg_t            cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [gyrsl_pkg::InDatW-1:0] in_data,
  output logic                       push,
  input  logic                       q_full,
  output gyrsl_pkg::cmd_t            push_cmd
);
  import gyrsl_pkg::*;

  logic [TimeW-1:0]        now_in, mt_in;
  logic [ConfW-1:0]        conf_in;
  logic [ErrW-1:0]         err_in;
  logic                    flags_ok;
  logic [TimeW:0]          age;
  logic                    age_ok;
  logic                    gate_ok;
  logic signed [ProdW-1:0] err_x, gain_x, prod_in;

  logic                    s1_valid;
  logic [TimeW-1:0]        s1_now;
  logic [ConfW-1:0]        s1_conf;
  logic                    s1_ok;
  logic signed [ProdW-1:0] s1_prod;

  logic signed [ProdW:0]   prod_x, lim_pos, lim_neg;
  logic signed [ProdW:0]   target_x;

  assign now_in   = in_data[62:0];
  assign mt_in    = in_data[125:63];
  assign flags_ok = &in_data[131:126];
  assign conf_in  = in_data[141:132];
  assign err_in   = in_data[157:142];

  // Borrow out of the subtract marks a match from the future.
  assign age     = {1'b0, now_in} - {1'b0, mt_in};
  assign age_ok  = !age[TimeW] && (age[TimeW-1:0] <= {{(TimeW-AgeW){1'b0}}, cfg.max_age});
  assign gate_ok = flags_ok && (conf_in >= cfg.min_conf) && age_ok;

  assign err_x   = {{GainW{err_in[ErrW-1]}}, err_in};
  assign gain_x  = {{ErrW{cfg.gain[GainW-1]}}, cfg.gain};
  assign prod_in = err_x * gain_x;

  assign push     = s1_valid && !q_full;
  assign in_ready = !s1_valid || !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_now  <= now_in;
      s1_conf <= conf_in;
      s1_ok   <= gate_ok;
      s1_prod <= prod_in;
    end
  end

  // Symmetric clamp to the rate limit.
  assign prod_x  = {s1_prod[ProdW-1], s1_prod};
  assign lim_pos = {{(ProdW+1-LimW){1'b0}}, cfg.max_rate};
  assign lim_neg = -lim_pos;

  always_comb begin
    priority if (prod_x > lim_pos) begin
      target_x = lim_pos;
    end else if (prod_x < lim_neg) begin
      target_x = lim_neg;
    end else begin
      target_x = prod_x;
    end
  end

  assign push_cmd.now    = s1_now;
  assign push_cmd.target = target_x[RateW-1:0];
  assign push_cmd.conf   = s1_conf;
  assign push_cmd.ok     = s1_ok;

endmodule

>>> hdl/gyrsl_queue.sv
`timescale 1ns / 1ps
// Two-entry queue between the front end and the rate stage.
module gyrsl_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gyrsl_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output gyrsl_pkg::cmd_t head_cmd
);
  import gyrsl_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/gyrsl_back.sv
`timescale 1ns / 1ps
// Back end: slew limit against the last rate and the output register.
module gyrsl_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [gyrsl_pkg::LimW-1:0]    max_slew,
  input  logic                          head_valid,
  input  gyrsl_pkg::cmd_t               head_cmd,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gyrsl_pkg::OutDatW-1:0] out_data
);
  import gyrsl_pkg::*;

  logic signed [RateW-1:0] last_rate, last_rate_next;
  logic signed [RateW:0]   delta, lim_pos, lim_neg, step;

  logic [TimeW-1:0]        o_stamp;
  logic [RateW-1:0]        o_rate;
  logic [ConfW-1:0]        o_conf;
  logic                    o_valid_cmd;

  assign pop = head_valid && (!out_valid || out_ready);

  assign delta   = {head_cmd.target[RateW-1], head_cmd.target} - {last_rate[RateW-1], last_rate};
  assign lim_pos = {{(RateW+1-LimW){1'b0}}, max_slew};
  assign lim_neg = -lim_pos;

  always_comb begin
    priority if (delta > lim_pos) begin
      step = lim_pos;
    end else if (delta < lim_neg) begin
      step = lim_neg;
    end else begin
      step = delta;
    end
  end

  // Gate failure drops the rate back to zero.
  assign last_rate_next = head_cmd.ok ? last_rate + step[RateW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_rate <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        last_rate <= last_rate_next;
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      o_stamp     <= head_cmd.now;
      o_rate      <= last_rate_next;
      o_conf      <= head_cmd.ok ? head_cmd.conf : '0;
      o_valid_cmd <= head_cmd.ok;
    end
  end

  assign out_data = {6'b0, o_valid_cmd, o_conf, o_rate, o_stamp};

endmodule

>>> hdl/gated_yaw_rate_slew_limiter.sv
`timescale 1ns / 1ps
// Top level of the gated yaw-rate slew limiter.
//
//  channel  | direction | transfer when            | carries
//  s_*      | in        | s_tvalid & s_tready      | route match and health snapshot
//  m_*      | out       | m_tvalid & m_tready      | yaw-rate command
//  cfg_*    | in        | cfg_valid & cfg_ready    | register index and value
//
// One match per cycle while neither side stalls; a command passes the front register, the queue
// and the output register before it is presented. The slew stage forms the next last_rate
// combinationally and registers it on each pop, so its loop does not slow the stream.
// Reset loads register defaults and clears last_rate. Either side may stall; the
// two-entry queue absorbs it.
module gated_yaw_rate_slew_limiter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // now_time[62:0], match_time[125:63], health_ready[126], cam_healthy[127],
  // link_ok[128], nav_ok[129], match_valid[130], floats_finite[131],
  // confidence[141:132], direction_error[157:142], zero[159:158]
  input  logic [gyrsl_pkg::InDatW-1:0]      s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // stamp[62:0], yaw_rate[94:63], out_confidence[104:95], cmd_valid[105],
  // zero[111:106]
  output logic [gyrsl_pkg::OutDatW-1:0]     m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gyrsl_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [gyrsl_pkg::CfgDatW-1:0]     cfg_data
);
  import gyrsl_pkg::*;

  cfg_t cfg;
  logic push, q_full, pop, head_valid;
  cmd_t push_cmd, head_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_conf <= ConfW'(500);
      cfg.max_age  <= AgeW'(200000000);
      cfg.gain     <= GainW'(1000);
      cfg.max_rate <= LimW'(1000000);
      cfg.max_slew <= LimW'(50000);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_CONF: cfg.min_conf <= cfg_data[ConfW-1:0];
        REG_MAX_AGE:  cfg.max_age  <= cfg_data[AgeW-1:0];
        REG_GAIN:     cfg.gain     <= cfg_data[GainW-1:0];
        REG_MAX_RATE: cfg.max_rate <= cfg_data[LimW-1:0];
        REG_MAX_SLEW: cfg.max_slew <= cfg_data[LimW-1:0];
        default:      cfg          <= cfg;
      endcase
    end
  end

  gyrsl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (s_tdata),
    .push     (push),
    .q_full   (q_full),
    .push_cmd (push_cmd)
  );

  gyrsl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  gyrsl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .max_slew   (cfg.max_slew),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata)
  );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the gated yaw-rate slew limiter: directed and random route matches.
module tb_top;
  import gyrsl_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic [TimeW-1:0]        now;
    logic [TimeW-1:0]        mtime;
    logic                    ready;
    logic                    camera;
    logic                    link;
    logic                    nav;
    logic                    mvalid;
    logic                    finite;
    logic [ConfW-1:0]        conf;
    logic signed [ErrW-1:0]  err;
  } match_t;

  typedef struct {
    logic [TimeW-1:0]        stamp;
    logic signed [RateW-1:0] rate;
    logic [ConfW-1:0]        conf;
    logic                    valid;
  } command_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [InDatW-1:0]    s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutDatW-1:0]   m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index = REG_MIN_CONF;
  logic [CfgDatW-1:0]   cfg_data = '0;

  // Register copy and rate memory of the predictor
  cfg_t shadow = '{min_conf: 10'd500, max_age: 40'd200000000, gain: 21'sd1000,
                   max_rate: 31'd1000000, max_slew: 31'd50000};
  longint last_rate = 0;

  match_t   match_pending_q[$];
  command_t cmd_expected_q[$];
  match_t   held_match;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles = 0;
  int n_errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_valid = 0;
  int n_settings = 0;

  gated_yaw_rate_slew_limiter uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Gate the match, then clamp and slew the rate against the stored one
  function automatic command_t advance_command(match_t m);
    logic [63:0] age;
    logic        gate_ok;
    longint      target;
    command_t    c;
    age = {1'b0, m.now} - {1'b0, m.mtime};
    gate_ok = m.ready && m.camera && m.link && m.nav && m.mvalid && m.finite &&
              (m.conf >= shadow.min_conf) && (m.now >= m.mtime) &&
              (age <= {24'd0, shadow.max_age});
    c.stamp = m.now;
    if (!gate_ok) begin
      last_rate = 0;
      c.rate = '0;
      c.conf = '0;
      c.valid = 1'b0;
    end else begin
      target = clamp_sym(longint'(m.err) * longint'($signed(shadow.gain)),
                         longint'(shadow.max_rate));
      last_rate = last_rate + clamp_sym(target - last_rate, longint'(shadow.max_slew));
      c.rate = last_rate[31:0];
      c.conf = m.conf;
      c.valid = 1'b1;
    end
    return c;
  endfunction

  function automatic logic [TimeW-1:0] rand63();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TimeW-1:0];
  endfunction

  // Caller keeps age no larger than now
  function automatic match_t good_match(logic [TimeW-1:0] now, logic [TimeW-1:0] age,
                                        logic [ConfW-1:0] conf, logic signed [ErrW-1:0] err);
    match_t m;
    m.now = now;
    m.mtime = now - age;
    m.ready = 1'b1;
    m.camera = 1'b1;
    m.link = 1'b1;
    m.nav = 1'b1;
    m.mvalid = 1'b1;
    m.finite = 1'b1;
    m.conf = conf;
    m.err = err;
    return m;
  endfunction

  function automatic void check_field(string what, longint expv, longint gotv);
    if (expv != gotv) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, expv, gotv);
      n_errors++;
    end
  endfunction

  // Driver: hold the item until its transfer, predict on transfer
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        cmd_expected_q.push_back(advance_command(held_match));
        n_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (match_pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          held_match = match_pending_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {2'b00, held_match.err, held_match.conf, held_match.finite,
                      held_match.mvalid, held_match.nav, held_match.link,
                      held_match.camera, held_match.ready, held_match.mtime,
                      held_match.now};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each command with the oldest prediction
  always @(posedge clk) begin : monitor
    command_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (cmd_expected_q.size() == 0) begin
          $display("%0t: unexpected command, expected none, actual stamp %0d yaw_rate %0d",
                   $time, m_tdata[62:0], $signed(m_tdata[94:63]));
          n_errors++;
        end else begin
          want = cmd_expected_q.pop_front();
          check_field("stamp", want.stamp, m_tdata[62:0]);
          check_field("yaw_rate", want.rate, $signed(m_tdata[94:63]));
          check_field("out_confidence", want.conf, m_tdata[104:95]);
          check_field("cmd_valid", want.valid, m_tdata[105]);
          n_checked++;
          if (m_tdata[105]) n_valid++;
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  task automatic write_reg(reg_idx_t idx, logic [CfgDatW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MIN_CONF: shadow.min_conf = val[ConfW-1:0];
      REG_MAX_AGE:  shadow.max_age = val[AgeW-1:0];
      REG_GAIN:     shadow.gain = val[GainW-1:0];
      REG_MAX_RATE: shadow.max_rate = val[LimW-1:0];
      REG_MAX_SLEW: shadow.max_slew = val[LimW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(cfg_t c);
    write_reg(REG_MIN_CONF, {30'd0, c.min_conf});
    write_reg(REG_MAX_AGE, c.max_age);
    write_reg(REG_GAIN, {{19{c.gain[GainW-1]}}, c.gain});
    write_reg(REG_MAX_RATE, {9'd0, c.max_rate});
    write_reg(REG_MAX_SLEW, {9'd0, c.max_slew});
    n_settings++;
  endtask

  task automatic wait_drained();
    while (match_pending_q.size() != 0 || s_tvalid || cmd_expected_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mostly matches that pass every gate, some with one gate broken, some noise
  task automatic queue_random_matches(int count);
    match_t                 m;
    logic [63:0]            age;
    logic [63:0]            base;
    logic [ConfW-1:0]       conf;
    logic signed [ErrW-1:0] err;
    int                     pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0:       age = 64'd0;
        1:       age = 64'(shadow.max_age);
        default: age = {$urandom, $urandom} % (64'(shadow.max_age) + 64'd1);
      endcase
      base = {1'b0, rand63()};
      if (base < age) base = base + age;
      conf = ($urandom_range(0, 19) == 0) ? 10'h3ff
                                          : 10'($urandom_range(shadow.min_conf, 1000));
      case ($urandom_range(0, 7))
        0:       err = 16'sh8000;
        1:       err = 16'sh7fff;
        2, 3:    err = 16'($urandom_range(0, 200)) - 16'sd100;
        default: err = 16'($urandom);
      endcase
      m = good_match(base[TimeW-1:0], age[TimeW-1:0], conf, err);
      if (pick >= 70 && pick < 90) begin
        case ($urandom_range(0, 8))
          0: m.ready = 1'b0;
          1: m.camera = 1'b0;
          2: m.link = 1'b0;
          3: m.nav = 1'b0;
          4: m.mvalid = 1'b0;
          5: m.finite = 1'b0;
          6: begin
            if (shadow.min_conf != 0) m.conf = 10'($urandom_range(0, shadow.min_conf - 1));
            else m.ready = 1'b0;
          end
          7: begin
            // stale match: age just past the limit or well beyond it
            age = 64'(shadow.max_age) + 64'd1 + 64'($urandom_range(0, 65535));
            base = age + (64'(rand63()) >> 1);
            m.now = base[TimeW-1:0];
            base = base - age;
            m.mtime = base[TimeW-1:0];
          end
          default: begin
            // match stamped after the decision time
            base = 64'(rand63()) >> 1;
            m.now = base[TimeW-1:0];
            base = base + 64'd1 + (64'(rand63()) >> 2);
            m.mtime = base[TimeW-1:0];
          end
        endcase
      end else if (pick >= 90) begin
        m.now = rand63();
        m.mtime = rand63();
        {m.ready, m.camera, m.link, m.nav, m.mvalid, m.finite} = 6'($urandom);
        m.conf = 10'($urandom);
        m.err = 16'($urandom);
      end
      match_pending_q.push_back(m);
    end
  endtask

  initial begin : stimulus
    localparam logic [TimeW-1:0] T0 = 63'd5000000000;
    localparam logic [TimeW-1:0] TMAX = '1;
    match_t m;
    cfg_t   c;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under the reset register values
    send_idle_pct = 18;
    recv_idle_pct = 52;
    match_pending_q.push_back(good_match(T0, 63'd1000, 10'd800, 16'sh7fff));
    match_pending_q.push_back(good_match(T0, 63'd1000, 10'd800, 16'sh7fff));
    match_pending_q.push_back(good_match(T0 + 1, 63'd0, 10'd500, 16'sh8000));
    match_pending_q.push_back(good_match(T0, 63'd200000000, 10'h3ff, 16'sd0));
    match_pending_q.push_back(good_match(T0, 63'd200000001, 10'd900, 16'sd100));
    match_pending_q.push_back(good_match(T0, 63'd5, 10'd499, 16'sd100));
    m = good_match(T0, 63'd0, 10'd700, 16'sd100);
    m.mtime = T0 + 1;
    match_pending_q.push_back(m);
    for (int g = 0; g < 6; g++) begin
      m = good_match(T0, 63'd10, 10'd700, 16'sd200);
      case (g)
        0: m.ready = 1'b0;
        1: m.camera = 1'b0;
        2: m.link = 1'b0;
        3: m.nav = 1'b0;
        4: m.mvalid = 1'b0;
        default: m.finite = 1'b0;
      endcase
      match_pending_q.push_back(m);
    end
    match_pending_q.push_back(good_match(TMAX, 63'd0, 10'd1000, 16'sd1));
    match_pending_q.push_back(good_match(63'd0, 63'd0, 10'd500, -16'sd1));
    match_pending_q.push_back(good_match(T0, 63'd1, 10'd600, 16'sd50));
    match_pending_q.push_back(good_match(T0, 63'd1, 10'd600, -16'sd50));
    m = good_match(TMAX, 63'd0, 10'd600, 16'sd50);
    m.mtime = '0;
    match_pending_q.push_back(m);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: c = '{min_conf: 10'd0, max_age: '1, gain: 21'sd1000000,
                 max_rate: '1, max_slew: '1};
        1: c = '{min_conf: 10'd1000, max_age: '0, gain: -21'sd1000000,
                 max_rate: '0, max_slew: '0};
        2: c = '{min_conf: 10'd300, max_age: 40'd1000000, gain: -21'sd1234,
                 max_rate: 31'd500000, max_slew: 31'd20000};
        4: c = '{min_conf: 10'd0, max_age: 40'd50000000, gain: 21'sd999999,
                 max_rate: '1, max_slew: 31'd1};
        default: begin
          c.min_conf = 10'($urandom_range(0, 1000));
          c.max_age = {8'($urandom_range(0, 255)), $urandom};
          c.gain = 21'(int'($urandom_range(0, 2000000)) - 1000000);
          c.max_rate = 31'($urandom);
          c.max_slew = 31'($urandom_range(0, 200000));
        end
      endcase
      if (ph < 2) begin
        send_idle_pct = 18;
        recv_idle_pct = 52;
      end else if (ph < 4) begin
        send_idle_pct = 52;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_settings(c);
      @(negedge clk);
      queue_random_matches(160);
      // hold the sender until every command is back, then carry on
      wait_drained();
      queue_random_matches(160);
      wait_drained();
    end

    repeat (8) @(negedge clk);
    $display("summary: %0d route matches sent, %0d commands checked, %0d of them valid",
             n_sent, n_checked, n_valid);
    $display("summary: reset values and %0d register settings, gate breaks, limit extremes",
             n_settings);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/gyrsl_pkg.sv
hdl/gyrsl_front.sv
hdl/gyrsl_queue.sv
hdl/gyrsl_back.sv
hdl/gated_yaw_rate_slew_limiter.sv
bench/tb_top.sv
